// File: hdl/kmv_pkg.sv
package kmv_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int ROW_DEPTH    = MAX_CAPACITY + 1;
  localparam int ADDR_W       = $clog2(ROW_DEPTH);

  localparam int WEIGHT_W = 11;
  localparam int VALUE_W  = 16;
  localparam int CAP_W    = 11;
  localparam int BEST_W   = 32;

  // common width for comparing row indexes against weights and capacity
  localparam int CMP_W = (ADDR_W > WEIGHT_W) ? ADDR_W : WEIGHT_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [VALUE_W-1:0]  value;
    logic                first;
    logic                last;
  } kmv_item_t;

endpackage

// File: hdl/kmv_ram.sv
module kmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_r[rd_addr_a];
    rd_data_b <= mem_r[rd_addr_b];
  end

endmodule

// File: hdl/kmv_front.sv
module kmv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kmv_pkg::WEIGHT_W-1:0] in_item_weight,
  input  logic [kmv_pkg::VALUE_W-1:0]  in_item_value,
  input  logic                         in_first_item,
  input  logic                         in_last_item,
  output logic                         q_valid,
  output kmv_pkg::kmv_item_t           q_item,
  input  logic                         q_pop
);
  import kmv_pkg::*;

  kmv_item_t            slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 push;
  logic                 pop;

  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= '{weight: in_item_weight, value: in_item_value,
                              first: in_first_item, last: in_last_item};
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/kmv_sweep.sv
module kmv_sweep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [kmv_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       q_valid,
  input  kmv_pkg::kmv_item_t         q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kmv_pkg::BEST_W-1:0] out_best_value,
  output logic                       out_final_answer
);
  import kmv_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_PUT} state_t;

  state_t              state_r;
  logic [CAP_W-1:0]    capacity_r;
  logic                clean_r;
  logic [ADDR_W-1:0]   c_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [VALUE_W-1:0]  v_r;
  logic                first_r;
  logic                last_r;
  logic                heavy_r;
  logic                s1_valid_r;
  logic [ADDR_W-1:0]   s1_c_r;
  logic                s1_ok_r;
  logic [BEST_W-1:0]   capt_r;
  logic                out_valid_r;
  logic [BEST_W-1:0]   out_best_r;
  logic                out_final_r;

  logic [CMP_W-1:0]    c_ext;
  logic [CMP_W-1:0]    w_ext;
  logic [CMP_W-1:0]    diff;
  logic [CMP_W-1:0]    cap_ext;
  logic                fits;
  logic [ADDR_W-1:0]   src_addr;
  logic [ADDR_W-1:0]   cap_sel;
  logic [BEST_W-1:0]   rd_old;
  logic [BEST_W-1:0]   rd_src;
  logic [BEST_W-1:0]   old_v;
  logic [BEST_W-1:0]   src_v;
  logic [BEST_W:0]     sum;
  logic [BEST_W-1:0]   take;
  logic [BEST_W-1:0]   new_v;
  logic                out_free;

  assign q_pop            = (state_r == ST_IDLE) && q_valid;
  assign out_valid        = out_valid_r;
  assign out_best_value   = out_best_r;
  assign out_final_answer = out_final_r;
  assign out_free         = !out_valid_r || !out_stall;

  always_comb begin
    c_ext    = CMP_W'(c_r);
    w_ext    = CMP_W'(w_r);
    fits     = (c_ext >= w_ext);
    diff     = c_ext - w_ext;
    src_addr = fits ? diff[ADDR_W-1:0] : c_r;
    cap_ext  = CMP_W'(capacity_r);
    cap_sel  = (cap_ext > CMP_W'(MAX_CAPACITY)) ? ADDR_W'(MAX_CAPACITY)
                                                 : cap_ext[ADDR_W-1:0];
  end

  // a first item sees an all-zero row: every read in a descending sweep hits
  // an entry not yet rewritten by this sweep
  always_comb begin
    old_v = first_r ? '0 : rd_old;
    src_v = first_r ? '0 : rd_src;
    sum   = {1'b0, src_v} + (BEST_W + 1)'(v_r);
    take  = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
    new_v = (s1_ok_r && (take > old_v)) ? take : old_v;
  end

  kmv_ram #(
    .WIDTH (BEST_W),
    .DEPTH (ROW_DEPTH)
  ) u_row (
    .clk       (clk),
    .wr_en     (s1_valid_r),
    .wr_addr   (s1_c_r),
    .wr_data   (new_v),
    .rd_addr_a (c_r),
    .rd_data_a (rd_old),
    .rd_addr_b (src_addr),
    .rd_data_b (rd_src)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= '0;
      clean_r     <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      s1_valid_r <= (state_r == ST_SWEEP);
      s1_c_r     <= c_r;
      s1_ok_r    <= fits && !heavy_r;
      if (s1_valid_r && (s1_c_r == cap_sel)) begin
        capt_r <= new_v;
      end
      // the put state refills the output register itself
      if (out_valid_r && !out_stall && (state_r != ST_PUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            c_r     <= ADDR_W'(MAX_CAPACITY);
            w_r     <= q_item.weight;
            v_r     <= q_item.value;
            first_r <= q_item.first || clean_r;
            last_r  <= q_item.last;
            heavy_r <= CMP_W'(q_item.weight) > CMP_W'(MAX_CAPACITY);
            clean_r <= 1'b0;
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (c_r == '0) begin
            state_r <= ST_DRAIN;
          end else begin
            c_r <= c_r - 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_PUT;
        end
        ST_PUT: begin
          // hold until the output register is free or being taken
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_best_r  <= capt_r;
            out_final_r <= last_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/knapsack_max_value_top.sv
// An accepted item is swept from row index 1024 down to 0, doing one
//   read-modify-write of the 1025-entry best-value row per cycle through a
//   single write port, then drain and put states; items are taken one at a time.
// Input queue holds two items and keeps accepting during a sweep until full.
// Reset: synchronous active-low; capacity goes to 0 and the row reads as all
//   zeros for the next item, with no clearing pass.
module knapsack_max_value_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [kmv_pkg::CAP_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kmv_pkg::WEIGHT_W-1:0] in_item_weight,
  input  logic [kmv_pkg::VALUE_W-1:0]  in_item_value,
  input  logic                         in_first_item,
  input  logic                         in_last_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kmv_pkg::BEST_W-1:0]   out_best_value,
  output logic                         out_final_answer
);
  import kmv_pkg::*;

  logic      q_valid;
  kmv_item_t q_item;
  logic      q_pop;

  kmv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item_weight (in_item_weight),
    .in_item_value  (in_item_value),
    .in_first_item  (in_first_item),
    .in_last_item   (in_last_item),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  kmv_sweep u_sweep (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_best_value   (out_best_value),
    .out_final_answer (out_final_answer)
  );

endmodule
